### hdl/ps2_device_byte_transmitter_assert.svh
// Assertion macros for the PS/2 device byte transmitter.
// No dependencies; included by the modules that carry checks.
`ifndef PS2_DEVICE_BYTE_TRANSMITTER_ASSERT_SVH
`define PS2_DEVICE_BYTE_TRANSMITTER_ASSERT_SVH

`ifndef SYNTHESIS
`define PS2TX_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ps2tx assertion failed");
`define PS2TX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ps2tx implication failed");
`define PS2TX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ps2tx sequence failed");
`else
`define PS2TX_ASSERT(lbl, clk, rst_n, prop)
`define PS2TX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PS2TX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hdl/ps2tx_pkg.sv
// Shared types and constants for the PS/2 device byte transmitter.
// No dependencies.
package ps2tx_pkg;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_BEGIN = 3'd1,
		PH_LOW   = 3'd2,
		PH_HIGH  = 3'd3,
		PH_GAP   = 3'd4
	} phase_t;

	localparam logic [3:0] STOP_POS = 4'd10;

	localparam logic [1:0] REG_HALF_BIT = 2'd0;
	localparam logic [1:0] REG_GAP      = 2'd1;
	localparam logic [1:0] REG_RETRY    = 2'd2;

	localparam logic [7:0]  HALF_BIT_RESET = 8'd30;
	localparam logic [15:0] GAP_RESET      = 16'd10000;
	localparam logic [7:0]  RETRY_RESET    = 8'd250;

	typedef struct packed {
		logic [7:0]  half_bit_ticks;
		logic [15:0] gap_ticks;
		logic [7:0]  retry_limit;
	} cfg_t;

	typedef struct packed {
		logic clock_pull_low;
		logic data_pull_low;
		logic busy_res;
		logic done_res;
		logic gave_up;
	} res_t;

endpackage

### hdl/ps2tx_core.sv
// Frame sequencer: per-tick line drive and send state.
// Depends on ps2tx_pkg and ps2_device_byte_transmitter_assert.svh.
`include "ps2_device_byte_transmitter_assert.svh"

module ps2tx_core #(
	parameter int COUNTER_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              start_req,
	input  logic [7:0]        tx_byte,
	input  logic              clock_line,
	input  logic              data_line,
	input  ps2tx_pkg::cfg_t   cfg,
	output ps2tx_pkg::res_t   res
);
	import ps2tx_pkg::*;

	localparam int GW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
	localparam logic [GW-1:0] CMAX = GW'((64'd1 << COUNTER_BITS) - 64'd1);

	phase_t                  phase_q, phase_n;
	logic [3:0]              bit_q, bit_n;
	logic [7:0]              held_q, held_n;
	logic [COUNTER_BITS-1:0] tick_q, tick_n;
	logic [7:0]              att_q, att_n;

	logic [COUNTER_BITS-1:0] half_c, gap_c;
	logic [GW-1:0]           gap_w;
	logic [7:0]              half_eff;
	logic [7:0]              att_inc;
	logic                    give_up;
	logic [3:0]              bit_inc;
	logic                    cur_bit;

	function automatic logic frame_bit(input logic [3:0] pos, input logic [7:0] byte_v);
		logic r;
		if (pos == 4'd0)
			r = 1'b0;
		else if (pos <= 4'd8)
			r = byte_v[3'(pos - 4'd1)];
		else if (pos == 4'd9)
			r = ~(^byte_v);
		else
			r = 1'b1;
		return r;
	endfunction

	always_comb begin
		half_eff = (cfg.half_bit_ticks == 8'd0) ? 8'd1 : cfg.half_bit_ticks;
		half_c   = COUNTER_BITS'(half_eff);
		gap_w    = GW'(cfg.gap_ticks);
		gap_c    = (gap_w > CMAX) ? COUNTER_BITS'(CMAX) : COUNTER_BITS'(gap_w);
		att_inc  = att_q + 8'd1;
		give_up  = (att_inc >= cfg.retry_limit);
		bit_inc  = bit_q + 4'd1;
		cur_bit  = frame_bit(bit_q, held_q);
	end

	always_comb begin
		phase_n = phase_q;
		bit_n   = bit_q;
		held_n  = held_q;
		tick_n  = tick_q;
		att_n   = att_q;
		res     = '0;
		case (phase_q)
			PH_BEGIN: begin
				if (!clock_line || !data_line) begin
					att_n  = att_inc;
					tick_n = '0;
					if (give_up) begin
						phase_n      = PH_IDLE;
						res.done_res = 1'b1;
						res.gave_up  = 1'b1;
					end else begin
						phase_n      = PH_BEGIN;
						res.busy_res = 1'b1;
					end
				end else begin
					bit_n              = 4'd0;
					phase_n            = PH_LOW;
					tick_n             = COUNTER_BITS'(1);
					res.clock_pull_low = 1'b1;
					res.data_pull_low  = 1'b1;
					res.busy_res       = 1'b1;
				end
			end
			PH_LOW: begin
				res.data_pull_low = ~cur_bit;
				res.busy_res      = 1'b1;
				if (tick_q >= half_c) begin
					phase_n = PH_HIGH;
					tick_n  = COUNTER_BITS'(1);
				end else begin
					tick_n             = tick_q + COUNTER_BITS'(1);
					res.clock_pull_low = 1'b1;
				end
			end
			PH_HIGH: begin
				if (tick_q < half_c) begin
					tick_n            = tick_q + COUNTER_BITS'(1);
					res.data_pull_low = ~cur_bit;
					res.busy_res      = 1'b1;
				end else if (bit_q >= STOP_POS) begin
					if (gap_c == '0) begin
						phase_n      = PH_IDLE;
						tick_n       = '0;
						res.done_res = 1'b1;
					end else begin
						phase_n      = PH_GAP;
						tick_n       = COUNTER_BITS'(1);
						res.busy_res = 1'b1;
					end
				end else if (!clock_line) begin
					// host inhibit between pulses: abort this attempt
					att_n  = att_inc;
					tick_n = '0;
					if (give_up) begin
						phase_n      = PH_IDLE;
						res.done_res = 1'b1;
						res.gave_up  = 1'b1;
					end else begin
						phase_n      = PH_BEGIN;
						res.busy_res = 1'b1;
					end
				end else begin
					bit_n              = bit_inc;
					phase_n            = PH_LOW;
					tick_n             = COUNTER_BITS'(1);
					res.clock_pull_low = 1'b1;
					res.data_pull_low  = ~frame_bit(bit_inc, held_q);
					res.busy_res       = 1'b1;
				end
			end
			PH_GAP: begin
				if (tick_q >= gap_c) begin
					phase_n      = PH_IDLE;
					tick_n       = '0;
					res.done_res = 1'b1;
				end else begin
					tick_n       = tick_q + COUNTER_BITS'(1);
					res.busy_res = 1'b1;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				if (start_req) begin
					held_n       = tx_byte;
					att_n        = 8'd0;
					bit_n        = 4'd0;
					tick_n       = '0;
					phase_n      = PH_BEGIN;
					res.busy_res = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= 4'd0;
			held_q  <= 8'd0;
			tick_q  <= '0;
			att_q   <= 8'd0;
		end else if (en) begin
			phase_q <= phase_n;
			bit_q   <= bit_n;
			held_q  <= held_n;
			tick_q  <= tick_n;
			att_q   <= att_n;
		end
	end

	`PS2TX_ASSERT_IMPL(a_gave_up_with_done, clk, arst_n, res.gave_up, res.done_res)
	`PS2TX_ASSERT_IMPL(a_done_not_busy, clk, arst_n, res.done_res, !res.busy_res && !res.clock_pull_low)
	`PS2TX_ASSERT(a_bit_in_frame, clk, arst_n, bit_q <= STOP_POS)
	`PS2TX_ASSERT_NEXT(a_start_to_begin, clk, arst_n, en && phase_q == PH_IDLE && start_req, phase_q == PH_BEGIN && held_q == $past(tx_byte))

endmodule

### hdl/ps2_device_byte_transmitter.sv
// Top level of the PS/2 device byte transmitter: APB registers and handshake.
// Depends on ps2tx_pkg and ps2tx_core.

// Device-side PS/2 byte sender. Feed one item per line-timing tick with the
// sampled clock and data levels; each item yields exactly one result that
// holds the line drive for that tick plus busy, done and gave-up status. The
// block takes one item every cycle: the sequencer state and the result are
// computed in a single pass and the result sits in one output register, so
// a result appears the cycle after its item and the input stalls only while
// that register is full and stalled. Registers: half_bit_ticks at 0x0,
// gap_ticks at 0x4, retry_limit at 0x8; write them only while idle.
module ps2_device_byte_transmitter #(
	parameter int COUNTER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        start_req,
	input  logic [7:0]  tx_byte,
	input  logic        clock_line,
	input  logic        data_line,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        clock_pull_low,
	output logic        data_pull_low,
	output logic        busy_res,
	output logic        done_res,
	output logic        gave_up,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ps2tx_pkg::*;

	cfg_t       cfg_q;
	res_t       res_c;
	res_t       res_q;
	logic       accept;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_bit_ticks <= HALF_BIT_RESET;
			cfg_q.gap_ticks      <= GAP_RESET;
			cfg_q.retry_limit    <= RETRY_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HALF_BIT: cfg_q.half_bit_ticks <= pwdata[7:0];
				REG_GAP:      cfg_q.gap_ticks      <= pwdata[15:0];
				REG_RETRY:    cfg_q.retry_limit    <= pwdata[7:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HALF_BIT: prdata = {24'd0, cfg_q.half_bit_ticks};
			REG_GAP:      prdata = {16'd0, cfg_q.gap_ticks};
			REG_RETRY:    prdata = {24'd0, cfg_q.retry_limit};
			default:      prdata = 32'd0;
		endcase
	end

	// a waiting result only blocks the input while it is itself stalled
	assign item_stall = res_valid && res_stall;
	assign accept     = item_valid && !item_stall;

	ps2tx_core #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (accept),
		.start_req  (start_req),
		.tx_byte    (tx_byte),
		.clock_line (clock_line),
		.data_line  (data_line),
		.cfg        (cfg_q),
		.res        (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (accept) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_c;
		end
	end

	assign clock_pull_low = res_q.clock_pull_low;
	assign data_pull_low  = res_q.data_pull_low;
	assign busy_res       = res_q.busy_res;
	assign done_res       = res_q.done_res;
	assign gave_up        = res_q.gave_up;

endmodule
